FILE: design/nearest_palette_index_search_macros.svh
// assertion macros for the nearest palette index search checker
// used by npis_checker only; no other dependencies
`ifndef NEAREST_PALETTE_INDEX_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_INDEX_SEARCH_MACROS_SVH

// same-cycle implication, disabled during reset
`define NPIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define NPIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/npis_pkg.sv
// shared types and the constant palette rom for the nearest palette index search
// no dependencies; imported by every rtl module of the block
package npis_pkg;

   localparam int PaletteDepth = 256;
   localparam int LastEntry    = 255;
   localparam int FixedCount   = 10;
   localparam int GrayBase     = 250;

   localparam int ChanWidth  = 8;
   localparam int IdxWidth   = 8;
   localparam int SqWidth    = 16;
   localparam int DistWidth  = 18;
   localparam int StepWidth  = 8;
   localparam int EntryWidth = 16;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } rgb_type;

   typedef rgb_type [PaletteDepth-1:0] palette_type;

   // best candidate seen so far
   typedef struct packed {
      logic                 valid;
      logic [IdxWidth-1:0]  idx;
      logic [DistWidth-1:0] sq_dist;
   } best_type;

   // transaction token handed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic                 first;
      logic                 last;
      logic [StepWidth-1:0] step;
      rgb_type              color;
      best_type             best;
   } token_type;

   // channel levels [shade][half saturation][quarter step]
   localparam logic [7:0] HSV_LEVEL [5][2][5] = '{
      '{'{8'd0, 8'd64, 8'd128, 8'd191, 8'd255}, '{8'd128, 8'd159, 8'd191, 8'd223, 8'd255}},
      '{'{8'd0, 8'd51, 8'd102, 8'd153, 8'd204}, '{8'd102, 8'd128, 8'd153, 8'd179, 8'd204}},
      '{'{8'd0, 8'd38, 8'd77,  8'd115, 8'd153}, '{8'd77,  8'd96,  8'd115, 8'd134, 8'd153}},
      '{'{8'd0, 8'd32, 8'd64,  8'd96,  8'd128}, '{8'd64,  8'd80,  8'd96,  8'd112, 8'd128}},
      '{'{8'd0, 8'd19, 8'd38,  8'd57,  8'd77 }, '{8'd38,  8'd48,  8'd57,  8'd67,  8'd77 }}
   };

   localparam rgb_type FIXED_RGB [10] = '{
      '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0,   8'd0  }, '{8'd255, 8'd255, 8'd0  },
      '{8'd0,   8'd255, 8'd0  }, '{8'd0,   8'd255, 8'd255}, '{8'd0,   8'd0,   8'd255},
      '{8'd255, 8'd0,   8'd255}, '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
      '{8'd192, 8'd192, 8'd192}
   };

   localparam logic [7:0] GRAY_LEVEL [6] = '{8'd51, 8'd91, 8'd132, 8'd173, 8'd214, 8'd255};

   // builds the whole palette at elaboration
   function automatic palette_type build_palette();
      palette_type p;
      int          off;
      int          grp;
      int          sub;
      int          shade;
      int          half;
      int          sector;
      int          q;
      int          kq;
      logic [7:0]  lv;
      logic [7:0]  hi;
      logic [7:0]  mid;
      logic [7:0]  lo;
      for (int i = 0; i < PaletteDepth; i++) begin
         if (i < FixedCount) begin
            p[i] = FIXED_RGB[i];
         end else if (i >= GrayBase) begin
            lv   = GRAY_LEVEL[i - GrayBase];
            p[i] = '{lv, lv, lv};
         end else begin
            off    = i - 10;
            grp    = off / 10;
            sub    = off % 10;
            shade  = sub / 2;
            half   = sub % 2;
            sector = grp / 4;
            q      = grp % 4;
            kq     = (sector % 2 == 1) ? (4 - q) : q;
            hi     = HSV_LEVEL[shade][half][4];
            mid    = HSV_LEVEL[shade][half][kq];
            lo     = HSV_LEVEL[shade][half][0];
            case (sector)
               0: begin
                  p[i] = '{hi, mid, lo};
               end
               1: begin
                  p[i] = '{mid, hi, lo};
               end
               2: begin
                  p[i] = '{lo, hi, mid};
               end
               3: begin
                  p[i] = '{lo, mid, hi};
               end
               4: begin
                  p[i] = '{mid, lo, hi};
               end
               default: begin
                  p[i] = '{hi, lo, mid};
               end
            endcase
         end
      end
      return p;
   endfunction

   localparam palette_type PALETTE = build_palette();

endpackage

FILE: design/npis_cell.sv
// one search cell: scores its own block of palette entries and merges the running best
// depends on npis_pkg for the token type and the palette rom
module npis_cell
   import npis_pkg::*;
#(
   parameter int CELL_POS = 0,
   parameter int BLOCK    = 64
) (
   input  logic      clock,
   input  logic      reset,
   input  token_type tok_in,
   output token_type tok_out
);

   localparam int EntryBase = 1 + CELL_POS * BLOCK;

   logic [EntryWidth-1:0] entry_num;
   logic                  entry_ok;
   logic [IdxWidth-1:0]   entry_idx;
   rgb_type               entry_rgb;
   logic [ChanWidth-1:0]  diff_r;
   logic [ChanWidth-1:0]  diff_g;
   logic [ChanWidth-1:0]  diff_b;

   token_type             tok_s1_ff;
   logic [SqWidth-1:0]    sq_r_ff;
   logic [SqWidth-1:0]    sq_g_ff;
   logic [SqWidth-1:0]    sq_b_ff;
   logic [IdxWidth-1:0]   idx_s1_ff;
   logic                  ok_s1_ff;

   logic [DistWidth-1:0]  entry_dist;
   best_type              local_eff;
   best_type              local_in;
   best_type              local_ff;
   best_type              merged;
   token_type             tok_out_in;
   token_type             tok_out_ff;

   // entry owned by this cell at this step
   assign entry_num = EntryWidth'(EntryBase) + EntryWidth'(tok_in.step);
   assign entry_ok  = (entry_num <= EntryWidth'(LastEntry));
   assign entry_idx = entry_num[IdxWidth-1:0];
   assign entry_rgb = PALETTE[entry_idx];

   // per-channel absolute differences
   assign diff_r = (entry_rgb.red > tok_in.color.red) ?
                   (entry_rgb.red - tok_in.color.red) : (tok_in.color.red - entry_rgb.red);
   assign diff_g = (entry_rgb.green > tok_in.color.green) ?
                   (entry_rgb.green - tok_in.color.green) :
                   (tok_in.color.green - entry_rgb.green);
   assign diff_b = (entry_rgb.blue > tok_in.color.blue) ?
                   (entry_rgb.blue - tok_in.color.blue) : (tok_in.color.blue - entry_rgb.blue);

   // first stage: squares registered
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_s1_ff.valid <= 1'b0;
      end else begin
         tok_s1_ff <= tok_in;
      end
      sq_r_ff   <= SqWidth'(diff_r) * SqWidth'(diff_r);
      sq_g_ff   <= SqWidth'(diff_g) * SqWidth'(diff_g);
      sq_b_ff   <= SqWidth'(diff_b) * SqWidth'(diff_b);
      idx_s1_ff <= entry_idx;
      ok_s1_ff  <= entry_ok;
   end

   // second stage: distance, local best and merge with the lower cells
   always_comb begin
      entry_dist = DistWidth'(sq_r_ff) + DistWidth'(sq_g_ff) + DistWidth'(sq_b_ff);
      local_eff = local_ff;
      if (tok_s1_ff.first) begin
         local_eff = '0;
      end
      local_in = local_eff;
      if (ok_s1_ff && (!local_eff.valid || (entry_dist < local_eff.sq_dist))) begin
         local_in.valid   = 1'b1;
         local_in.idx     = idx_s1_ff;
         local_in.sq_dist = entry_dist;
      end
      // lower cells hold lower indices, so only a strictly smaller distance wins
      merged = tok_s1_ff.best;
      if (local_in.valid &&
          (!tok_s1_ff.best.valid || (local_in.sq_dist < tok_s1_ff.best.sq_dist))) begin
         merged = local_in;
      end
      tok_out_in      = tok_s1_ff;
      tok_out_in.best = merged;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_out_ff.valid <= 1'b0;
      end else begin
         tok_out_ff <= tok_out_in;
      end
      if (tok_s1_ff.valid) begin
         local_ff <= local_in;
      end
   end

   assign tok_out = tok_out_ff;

endmodule

FILE: design/npis_ctrl.sv
// sequencer for the search: takes a colour, steps the cell chain, buffers the result
// depends on npis_pkg for the token type
module npis_ctrl
   import npis_pkg::*;
#(
   parameter int BLOCK = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rgb_type              req_color,
   output token_type            tok_out,
   input  token_type            chain_out,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IdxWidth-1:0]  rsp_palette_index,
   output logic [DistWidth-1:0] rsp_min_distance
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DRAIN
   } state_type;

   localparam logic [StepWidth-1:0] LastStep = StepWidth'(BLOCK - 1);

   state_type             state_ff;
   logic [StepWidth-1:0]  step_ff;
   rgb_type               color_ff;
   logic                  rsp_valid_ff;
   logic [IdxWidth-1:0]   rsp_idx_ff;
   logic [DistWidth-1:0]  rsp_dist_ff;
   logic                  hold_valid_ff;
   logic [IdxWidth-1:0]   hold_idx_ff;
   logic [DistWidth-1:0]  hold_dist_ff;

   logic                  req_take;
   logic                  rsp_free;
   logic                  result_in;

   assign req_stall = (state_ff != IDLE) || hold_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign result_in = chain_out.valid && chain_out.last;

   // token presented to the first cell
   always_comb begin
      tok_out       = '0;
      tok_out.valid = (state_ff == SCAN);
      tok_out.first = (step_ff == '0);
      tok_out.last  = (step_ff == LastStep);
      tok_out.step  = step_ff;
      tok_out.color = color_ff;
   end

   // state, step counter and result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (req_take) begin
                  color_ff <= req_color;
                  step_ff  <= '0;
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LastStep) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               if (result_in) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase

         // output register with a one-deep hold behind it
         if (rsp_free) begin
            if (hold_valid_ff) begin
               rsp_valid_ff <= 1'b1;
               rsp_idx_ff   <= hold_idx_ff;
               rsp_dist_ff  <= hold_dist_ff;
               if (result_in) begin
                  hold_idx_ff  <= chain_out.best.idx;
                  hold_dist_ff <= chain_out.best.sq_dist;
               end else begin
                  hold_valid_ff <= 1'b0;
               end
            end else if (result_in) begin
               rsp_valid_ff <= 1'b1;
               rsp_idx_ff   <= chain_out.best.idx;
               rsp_dist_ff  <= chain_out.best.sq_dist;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end else if (result_in) begin
            hold_valid_ff <= 1'b1;
            hold_idx_ff   <= chain_out.best.idx;
            hold_dist_ff  <= chain_out.best.sq_dist;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = rsp_idx_ff;
   assign rsp_min_distance  = rsp_dist_ff;

endmodule

FILE: design/nearest_palette_index_search.sv
// one colour at a time: a new colour is accepted only after the result of the last one
// has left the cell chain, which takes the scan of each cell over its block of entries
// plus the two stages per chain cell
// a finished result waits in the output register while the next colour is taken
// reset: synchronous, active high; clears control state, no clearing pass needed
module nearest_palette_index_search
   import npis_pkg::*;
#(
   parameter int NUM_CELLS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ChanWidth-1:0] req_red,
   input  logic [ChanWidth-1:0] req_green,
   input  logic [ChanWidth-1:0] req_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [IdxWidth-1:0]  rsp_palette_index,
   output logic [DistWidth-1:0] rsp_min_distance
);

   localparam int Block = (LastEntry + NUM_CELLS - 1) / NUM_CELLS;

   rgb_type   req_color;
   token_type chain [NUM_CELLS+1];

   assign req_color = '{req_red, req_green, req_blue};

   // sequencer and result buffer
   npis_ctrl #(
      .BLOCK(Block)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_color         (req_color),
      .tok_out           (chain[0]),
      .chain_out         (chain[NUM_CELLS]),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_palette_index (rsp_palette_index),
      .rsp_min_distance  (rsp_min_distance)
   );

   // row of search cells, each owning a contiguous block of entries
   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      npis_cell #(
         .CELL_POS(c),
         .BLOCK   (Block)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain[c]),
         .tok_out (chain[c+1])
      );
   end

endmodule

FILE: design/npis_checker.sv
// port-level checks for the nearest palette index search, bound to the top level
// depends on nearest_palette_index_search_macros.svh
`include "nearest_palette_index_search_macros.svh"

module npis_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_red,
   input logic [7:0]  req_green,
   input logic [7:0]  req_blue,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_palette_index,
   input logic [17:0] rsp_min_distance
);

   // a stalled result keeps its payload
   `NPIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_palette_index) && $stable(rsp_min_distance), "stalled result changed")

   // entry zero is never chosen
   `NPIS_ASSERT_NOW(a_index_nonzero, clock, reset, rsp_valid, rsp_palette_index != 8'd0, "palette index zero returned")

   // distance within the largest possible squared rgb distance
   `NPIS_ASSERT_NOW(a_dist_range, clock, reset, rsp_valid, rsp_min_distance <= 18'd195075, "distance out of range")

   // a transaction keeps the block busy in the following cycle
   `NPIS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "block accepted two transactions back to back")

endmodule

bind nearest_palette_index_search npis_checker u_checker (.*);
